FILE: sv/adc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and pattern tables for the ad domain classifier.
// No dependencies; every other file of the block imports this package.
package adc_pkg;

    localparam int MAX_LEN = 512;
    localparam int WIN_LEN = 21;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    localparam int N_HOST   = 30;
    localparam int N_STRONG = 13;
    localparam int N_WEAK   = 9;
    localparam int N_SHORT  = 3;

    localparam logic [2:0] TIER_NONE   = 3'd0;
    localparam logic [2:0] TIER_HOST   = 3'd1;
    localparam logic [2:0] TIER_STRONG = 3'd2;
    localparam logic [2:0] TIER_WEAK   = 3'd3;
    localparam logic [2:0] TIER_SHORT  = 3'd4;

    localparam logic [1:0] SK_NONE = 2'd0;
    localparam logic [1:0] SK_WAIT = 2'd1;
    localparam logic [1:0] SK_PASS = 2'd2;
    localparam logic [1:0] SK_FAIL = 2'd3;

    localparam logic [2:0] PREFIX_DONE = 3'd4;

    typedef struct packed {
        logic [7:0] domain_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       is_ad;
        logic [2:0] match_tier;
    } t_out_item;

    // One step of the tracker: a transaction taken from the input register
    typedef struct packed {
        logic       take;
        logic [7:0] domain_byte;
        logic       last_byte;
    } t_step;

    typedef struct packed {
        logic               host;
        logic               high_kw;
        logic               mid_kw;
        logic [N_SHORT-1:0] short_end;
        logic [N_SHORT-1:0] short_before_ok;
    } t_hits;

    // Entry 0 is the newest byte
    typedef logic [WIN_LEN-1:0][7:0] t_window;

    // Patterns are right-aligned: byte 0 holds the last character
    typedef logic [8*WIN_LEN-1:0] t_pat;

    localparam logic [3:0][7:0] PREFIX = "www.";

    localparam t_pat HOST_PAT [N_HOST] = '{
        {"double", "click.net"}, {"googlead", "services.com"},
        {"googlesyn", "dication.com"}, {"google-", "analytics.com"},
        {"googletag", "manager.com"}, {"face", "book.com/tr"},
        {"amazon-", "adsystem.com"}, "adsco.re",
        "tanx.com", "allyes.com", "guohead.com", "mediav.com", "iads.cn",
        {"ad", "master.com.cn"}, {"miao", "zhen.com"}, "pangolin-sdk.com",
        {"gdt.q", "q.com"}, {"e.q", "q.com"}, {"ad.q", "q.com"},
        "adnxs.com", {"tab", "oola.com"}, {"out", "brain.com"},
        "adsafeprotected.com", "moatads.com", "scorecardresearch.com",
        {"hm.bai", "du.com"}, {"cn", "zz.com"}, "51.la", {"log.m", "i.com"},
        {"analysis.q", "q.com"}
    };

    localparam t_pat STRONG_PAT [N_STRONG] = '{
        {"double", "click"}, {"googlesyn", "dication"}, "googleads", "tanx",
        "pangolin", {"ad", "master"}, "adsystem", "adserver", {"miao", "zhen"},
        "dianjoy", "iads", "guanggao", "advertisement"
    };

    localparam t_pat WEAK_PAT [N_WEAK] = '{
        "analytics", "tracking", "stat", "tongji", "tracker",
        "ad-", "ad_", "-ad", "_ad"
    };

    localparam t_pat SHORT_PAT [N_SHORT] = '{"ad", "ads", "gg"};

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Count of characters; patterns hold no zero byte
    function automatic int pat_len(input t_pat p);
        int n;
        n = 0;
        for (int j = 0; j < WIN_LEN; j++) begin
            if (p[8*j +: 8] != 8'd0) begin
                n = j + 1;
            end
        end
        return n;
    endfunction

    function automatic logic tail_match(input t_window w, input t_pat p, input int len);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < WIN_LEN; j++) begin
            if (j < len && w[j] != p[8*j +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: sv/ad_domain_classifier_core.sv
`timescale 1ns / 1ps
// Top level of the ad domain classifier: input register, tracker, result register.
// Depends on adc_pkg and adc_track.
//
//  channel | valid        | stall        | payload                  | carries
//  --------+--------------+--------------+--------------------------+-------------------
//  in      | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)   | one name byte
//  out     | o_out_valid  | i_out_stall  | o_out_data (t_out_item)  | verdict per name
//
// One byte per cycle sustained while no last byte waits on a stalled result; a last
// byte passes the input register, then the comparator bank into the result register.
// Reset (synchronous, active low) empties both registers and the per-name state.
// A stalled result holds; bytes that end no name keep flowing, and a last byte
// waits in the input register until the result register is free.
module ad_domain_classifier_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  adc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output adc_pkg::t_out_item o_out_data
);
    import adc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      adv;
    t_step     step;
    t_out_item result;

    assign adv = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    assign step.take        = adv;
    assign step.domain_byte = r_in.domain_byte;
    assign step.last_byte   = r_in.last_byte;

    adc_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in.last_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_is_ad_matches_tier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_ad == (o_out_data.match_tier != TIER_NONE)))
        else $error("is_ad disagrees with match_tier");

    a_tier_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.match_tier <= TIER_SHORT))
        else $error("match_tier out of range");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last_byte) |=> o_out_valid)
        else $error("last byte processed without a result");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in.last_byte))
        else $error("input stalled without a blocked result");

endmodule

FILE: sv/adc_match.sv
`timescale 1ns / 1ps
// Parallel pattern comparators against the byte window.
// Depends on adc_pkg for the pattern tables and compare helpers.
module adc_match (
    input  adc_pkg::t_window            i_win,
    input  logic [adc_pkg::POS_W-1:0]   i_pos,
    input  logic                        i_pre_full,
    output adc_pkg::t_hits              o_hits
);
    import adc_pkg::*;

    t_window             win_fold;
    logic [N_HOST-1:0]   host_hit;
    logic [N_STRONG-1:0] strong_hit;
    logic [N_WEAK-1:0]   weak_hit;
    logic [N_SHORT-1:0]  short_end;
    logic [N_SHORT-1:0]  short_before_ok;

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            win_fold[i] = fold(i_win[i]);
        end
    end

    for (genvar k = 0; k < N_HOST; k++) begin : g_host
        localparam int L = pat_len(HOST_PAT[k]);
        // with a www. prefix the match must start after it
        assign host_hit[k] = tail_match(win_fold, HOST_PAT[k], L) &&
                             (i_pre_full ? (i_pos >= POS_W'(L + 3))
                                         : (i_pos >= POS_W'(L - 1)));
    end

    for (genvar k = 0; k < N_STRONG; k++) begin : g_strong
        localparam int L = pat_len(STRONG_PAT[k]);
        assign strong_hit[k] = tail_match(i_win, STRONG_PAT[k], L) &&
                               (i_pos >= POS_W'(L - 1));
    end

    for (genvar k = 0; k < N_WEAK; k++) begin : g_weak
        localparam int L = pat_len(WEAK_PAT[k]);
        assign weak_hit[k] = tail_match(i_win, WEAK_PAT[k], L) &&
                             (i_pos >= POS_W'(L - 1));
    end

    for (genvar k = 0; k < N_SHORT; k++) begin : g_short
        localparam int L = pat_len(SHORT_PAT[k]);
        assign short_end[k] = tail_match(i_win, SHORT_PAT[k], L) &&
                              (i_pos >= POS_W'(L - 1));
        // the byte before the keyword, if there is one
        assign short_before_ok[k] = (i_pos >= POS_W'(L)) ? !is_alnum(i_win[L]) : 1'b1;
    end

    assign o_hits.host            = (|host_hit) && (i_pos <= POS_W'(MAX_LEN - 2));
    assign o_hits.high_kw         = |strong_hit;
    assign o_hits.mid_kw          = |weak_hit;
    assign o_hits.short_end       = short_end;
    assign o_hits.short_before_ok = short_before_ok;

endmodule

FILE: sv/adc_track.sv
`timescale 1ns / 1ps
// Per-name state: byte window, position, www. prefix progress, tier flags and
// short keyword status. Depends on adc_pkg and adc_match.
module adc_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adc_pkg::t_step      i_step,
    output adc_pkg::t_out_item  o_result
);
    import adc_pkg::*;

    t_window                    r_win;
    logic [POS_W-1:0]           r_pos;
    logic [2:0]                 r_pre;
    logic [2:0]                 r_flags;
    logic [N_SHORT-1:0][1:0]    r_sk;
    logic                       r_ended;

    t_window                    n_win;
    logic [POS_W-1:0]           n_pos;
    logic [2:0]                 n_pre;
    logic [2:0]                 n_flags;
    logic [N_SHORT-1:0][1:0]    n_sk;
    logic                       n_ended;

    logic                       active;
    logic                       byte_ok;
    logic                       short_hit;
    logic [2:0]                 tier;
    t_hits                      hits;

    assign active  = i_step.take && !r_ended;
    assign byte_ok = active && (i_step.domain_byte != 8'd0);

    assign n_win = byte_ok ? {r_win[WIN_LEN-2:0], i_step.domain_byte} : r_win;

    always_comb begin
        n_pre = r_pre;
        if (byte_ok && r_pos < POS_W'(4) && r_pre == r_pos[2:0] &&
            fold(i_step.domain_byte) == PREFIX[2'd3 - r_pos[1:0]]) begin
            n_pre = r_pre + 3'd1;
        end
    end

    adc_match u_match (
        .i_win      (n_win),
        .i_pos      (r_pos),
        .i_pre_full (n_pre == PREFIX_DONE),
        .o_hits     (hits)
    );

    assign n_flags = byte_ok ? (r_flags | {hits.mid_kw, hits.high_kw, hits.host}) : r_flags;

    always_comb begin
        n_sk = r_sk;
        if (byte_ok) begin
            for (int k = 0; k < N_SHORT; k++) begin
                if (n_sk[k] == SK_WAIT) begin
                    n_sk[k] = is_alnum(i_step.domain_byte) ? SK_FAIL : SK_PASS;
                end
                if (n_sk[k] == SK_NONE && hits.short_end[k]) begin
                    n_sk[k] = hits.short_before_ok[k] ? SK_WAIT : SK_FAIL;
                end
            end
        end
    end

    assign n_pos   = (byte_ok && r_pos < POS_W'(MAX_LEN)) ? r_pos + POS_W'(1) : r_pos;
    assign n_ended = r_ended | (active && i_step.domain_byte == 8'd0);

    always_comb begin
        short_hit = 1'b0;
        for (int k = 0; k < N_SHORT; k++) begin
            if (n_sk[k] == SK_WAIT || n_sk[k] == SK_PASS) begin
                short_hit = 1'b1;
            end
        end
    end

    always_comb begin
        if (n_flags[0]) begin
            tier = TIER_HOST;
        end else if (n_flags[1]) begin
            tier = TIER_STRONG;
        end else if (n_flags[2]) begin
            tier = TIER_WEAK;
        end else if (short_hit) begin
            tier = TIER_SHORT;
        end else begin
            tier = TIER_NONE;
        end
    end

    assign o_result.match_tier = tier;
    assign o_result.is_ad      = (tier != TIER_NONE);

    // Window entries are only read where the position shows them filled
    always_ff @(posedge i_clk) begin
        if (i_step.take) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_pre   <= '0;
            r_flags <= '0;
            r_sk    <= '0;
            r_ended <= 1'b0;
        end else if (i_step.take && i_step.last_byte) begin
            // name finished: clear for the next one
            r_pos   <= '0;
            r_pre   <= '0;
            r_flags <= '0;
            r_sk    <= '0;
            r_ended <= 1'b0;
        end else if (i_step.take) begin
            r_pos   <= n_pos;
            r_pre   <= n_pre;
            r_flags <= n_flags;
            r_sk    <= n_sk;
            r_ended <= n_ended;
        end
    end

endmodule
